// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the glob pattern syntax checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low
`define GPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define GPSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/gpsc_pkg.sv =====
// Types and byte constants for the glob pattern syntax checker
package gpsc_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_ESC        = 3'd1,
    MODE_STAR       = 3'd2,
    MODE_RANGE_OPEN = 3'd3,
    MODE_RANGE      = 3'd4,
    MODE_RANGE_ESC  = 3'd5
  } scan_mode_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_UNEVEN    = 4'd1,
    ERR_DSTAR     = 4'd2,
    ERR_EMPTY     = 4'd3,
    ERR_TRAIL     = 4'd4,
    ERR_ESCSLASH  = 4'd5,
    ERR_NESTED    = 4'd6,
    ERR_SLASHRNG  = 4'd7,
    ERR_NONASCII  = 4'd8
  } err_code_e;

  localparam logic [7:0] CharLBracket  = 8'h5B;  // [
  localparam logic [7:0] CharRBracket  = 8'h5D;  // ]
  localparam logic [7:0] CharQuestion  = 8'h3F;  // ?
  localparam logic [7:0] CharStar      = 8'h2A;  // *
  localparam logic [7:0] CharSlash     = 8'h2F;  // /
  localparam logic [7:0] CharBackslash = 8'h5C;  // backslash
  localparam logic [7:0] AsciiLow      = 8'd32;
  localparam logic [7:0] AsciiHigh     = 8'd127;

endpackage

// ===== rtl/core/glob_pattern_syntax_checker_unit.sv =====
// Glob pattern syntax checker: byte scanner with a one-word result register
//
//   channel | direction | fields                        | handshake
//   --------+-----------+-------------------------------+------------------------
//   in      | input     | pattern_byte_i, last_byte_i   | in_valid_i / in_ready_o
//   out     | output    | is_glob_o, error_code_o       | out_valid_o / out_ready_i
//
// One byte is taken per cycle while in_ready_o is high; the mode register and the
// scan flags are the only loop, updated in the cycle a byte is taken.
// A word marked last loads the result register, and the result appears in the next cycle.
// Input stalls only while a result is held and out_ready_i is low.
// Reset (rst_ni low, asynchronous) returns to top-level mode with no error.
`include "assert_macros.svh"

module glob_pattern_syntax_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pattern_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_glob_o,
  output logic [3:0] error_code_o
);

  gpsc_pkg::scan_mode_e mode_q, mode_d;
  gpsc_pkg::err_code_e  err_q, err_d;
  logic                 glob_q, glob_d;
  logic                 nonasc_q, nonasc_d;

  logic                 out_valid_q;
  logic                 out_glob_q, out_glob_d;
  gpsc_pkg::err_code_e  out_err_q, out_err_d;

  logic                 in_acc;
  logic                 do_top;
  logic                 do_range;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Next state of the scanner
  always_comb begin
    mode_d   = mode_q;
    err_d    = err_q;
    glob_d   = glob_q;
    nonasc_d = nonasc_q;
    do_top   = 1'b0;
    do_range = 1'b0;

    // Bytes after the first error are dropped
    if (err_q == gpsc_pkg::ERR_NONE) begin
      unique case (mode_q)
        gpsc_pkg::MODE_STAR: begin
          if (pattern_byte_i == gpsc_pkg::CharStar) err_d = gpsc_pkg::ERR_DSTAR;
          else do_top = 1'b1;
        end
        gpsc_pkg::MODE_ESC: begin
          if (pattern_byte_i == gpsc_pkg::CharBackslash ||
              pattern_byte_i == gpsc_pkg::CharSlash) err_d = gpsc_pkg::ERR_ESCSLASH;
          else mode_d = gpsc_pkg::MODE_NORMAL;
        end
        gpsc_pkg::MODE_RANGE_OPEN: begin
          if (pattern_byte_i == gpsc_pkg::CharRBracket) err_d = gpsc_pkg::ERR_EMPTY;
          else do_range = 1'b1;
        end
        gpsc_pkg::MODE_RANGE: begin
          do_range = 1'b1;
        end
        gpsc_pkg::MODE_RANGE_ESC: begin
          if (pattern_byte_i == gpsc_pkg::CharBackslash ||
              pattern_byte_i == gpsc_pkg::CharSlash) err_d = gpsc_pkg::ERR_ESCSLASH;
          else mode_d = gpsc_pkg::MODE_RANGE;
        end
        default: begin
          do_top = 1'b1;
        end
      endcase
    end

    if (do_top) begin
      if (pattern_byte_i < gpsc_pkg::AsciiLow || pattern_byte_i > gpsc_pkg::AsciiHigh) begin
        nonasc_d = 1'b1;
      end
      case (pattern_byte_i)
        gpsc_pkg::CharBackslash: mode_d = gpsc_pkg::MODE_ESC;
        gpsc_pkg::CharLBracket: begin
          glob_d = 1'b1;
          mode_d = gpsc_pkg::MODE_RANGE_OPEN;
        end
        gpsc_pkg::CharRBracket: err_d = gpsc_pkg::ERR_UNEVEN;
        gpsc_pkg::CharQuestion: begin
          glob_d = 1'b1;
          mode_d = gpsc_pkg::MODE_NORMAL;
        end
        gpsc_pkg::CharStar: begin
          glob_d = 1'b1;
          mode_d = gpsc_pkg::MODE_STAR;
        end
        default: mode_d = gpsc_pkg::MODE_NORMAL;
      endcase
    end

    if (do_range) begin
      case (pattern_byte_i)
        gpsc_pkg::CharBackslash: mode_d = gpsc_pkg::MODE_RANGE_ESC;
        gpsc_pkg::CharLBracket:  err_d  = gpsc_pkg::ERR_NESTED;
        gpsc_pkg::CharRBracket:  mode_d = gpsc_pkg::MODE_NORMAL;
        gpsc_pkg::CharSlash:     err_d  = gpsc_pkg::ERR_SLASHRNG;
        default:                 mode_d = gpsc_pkg::MODE_RANGE;
      endcase
    end
  end

  // Result word from the state after this byte
  always_comb begin
    out_err_d = err_d;
    if (err_d == gpsc_pkg::ERR_NONE) begin
      if (mode_d == gpsc_pkg::MODE_ESC || mode_d == gpsc_pkg::MODE_RANGE_ESC) begin
        out_err_d = gpsc_pkg::ERR_TRAIL;
      end else if (mode_d == gpsc_pkg::MODE_RANGE_OPEN || mode_d == gpsc_pkg::MODE_RANGE) begin
        out_err_d = gpsc_pkg::ERR_UNEVEN;
      end else if (glob_d && nonasc_d) begin
        out_err_d = gpsc_pkg::ERR_NONASCII;
      end
    end
    out_glob_d = (out_err_d == gpsc_pkg::ERR_NONE) ? glob_d : 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= gpsc_pkg::MODE_NORMAL;
      err_q    <= gpsc_pkg::ERR_NONE;
      glob_q   <= 1'b0;
      nonasc_q <= 1'b0;
    end else if (in_acc) begin
      if (last_byte_i) begin
        // Pattern done: start the next one from scratch
        mode_q   <= gpsc_pkg::MODE_NORMAL;
        err_q    <= gpsc_pkg::ERR_NONE;
        glob_q   <= 1'b0;
        nonasc_q <= 1'b0;
      end else begin
        mode_q   <= mode_d;
        err_q    <= err_d;
        glob_q   <= glob_d;
        nonasc_q <= nonasc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      out_glob_q <= out_glob_d;
      out_err_q  <= out_err_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_glob_o    = out_glob_q;
  assign error_code_o = out_err_q;

  `GPSC_ASSERT(a_reset_after_last,
    (in_acc && last_byte_i) |=> (mode_q == gpsc_pkg::MODE_NORMAL &&
      err_q == gpsc_pkg::ERR_NONE && !glob_q && !nonasc_q),
    "scanner state not cleared after last word")
  `GPSC_ASSERT(a_err_sticky,
    (in_acc && !last_byte_i && err_q != gpsc_pkg::ERR_NONE) |=> (err_q == $past(err_q)),
    "first error overwritten")
  `GPSC_ASSERT(a_glob_clear_on_err,
    (out_valid_q && out_err_q != gpsc_pkg::ERR_NONE) |-> !out_glob_q,
    "is_glob set on an erroneous pattern")
  `GPSC_ASSERT(a_result_from_last,
    $rose(out_valid_q) |-> $past(in_acc && last_byte_i),
    "result appeared without a last word")
  `GPSC_ASSERT_ALWAYS(a_reset_no_result,
    !rst_ni |-> !out_valid_q,
    "result valid during reset")

endmodule
